### hdl/ptc_pkg.sv
// Shared types and constants for the procedural texture color block.
`default_nettype none

package ptc_pkg;

    // Fixed-point layout of the scaled coordinate.
    localparam int FRAC_BITS   = 16;
    localparam int SCALE_BITS  = 24;
    localparam int MORTAR_BITS = 16;
    localparam int MODE_BITS   = 2;
    // Product bits that matter: 16 fraction bits dropped by flooring,
    // 16 kept fraction bits and the low integer bit.
    localparam int PROD_BITS   = 2 * FRAC_BITS + 1;

    localparam logic [FRAC_BITS-1:0] HALF_Q16 = 16'h8000;

    // Texture modes; the unused code behaves as uniform.
    localparam logic [MODE_BITS-1:0] MODE_UNIFORM = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_CHECKER = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_BRICK   = 2'd2;

    // Configuration register indexes.
    localparam int CFG_INDEX_BITS = 3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MODE   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COLOR_A = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COLOR_B = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SCALE  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MORTAR = 3'd4;

    localparam logic [SCALE_BITS-1:0] SCALE_RESET = 24'h010000;

    // One scaled coordinate: low bit of the truncated integer part and
    // the floor-fraction.
    typedef struct packed {
        logic                 int_bit;
        logic [FRAC_BITS-1:0] frac;
    } t_scaled;

endpackage

`default_nettype wire

### hdl/ptc_scale.sv
// Two-stage coordinate scaler: multiply, then truncation parity and fraction.
`default_nettype none

module ptc_scale #(
    parameter int COORD_BITS = 32
) (
    input  wire logic                                i_clk,
    input  wire logic signed [COORD_BITS-1:0]        i_coord,
    input  wire logic [ptc_pkg::SCALE_BITS-1:0]      i_scale,
    output ptc_pkg::t_scaled                         o_scaled
);

    localparam int PB = ptc_pkg::PROD_BITS;
    localparam int FB = ptc_pkg::FRAC_BITS;

    logic [PB-1:0]    w_ext;
    logic [PB-1:0]    n_prod;
    logic [PB-1:0]    r_prod;
    logic             r_neg;
    logic             r_scale_nz;
    ptc_pkg::t_scaled n_scaled;
    ptc_pkg::t_scaled r_scaled;

    // Only the product modulo 2^33 is needed, so the coordinate is
    // sign-extended or truncated to that width.
    assign w_ext  = PB'(i_coord);
    assign n_prod = w_ext * PB'(i_scale);

    always_ff @(posedge i_clk) begin
        r_prod     <= n_prod;
        r_neg      <= i_coord[COORD_BITS-1];
        r_scale_nz <= (i_scale != '0);
    end

    // A negative value with a nonzero fraction truncates one above its
    // floor, which flips the low integer bit.
    always_comb begin
        n_scaled.frac    = r_prod[2*FB-1:FB];
        n_scaled.int_bit = r_prod[2*FB]
                         ^ (r_neg & r_scale_nz & (r_prod[2*FB-1:FB] != '0));
    end

    always_ff @(posedge i_clk) begin
        r_scaled <= n_scaled;
    end

    assign o_scaled = r_scaled;

endmodule

`default_nettype wire

### hdl/procedural_texture_color.sv
// Top level of the procedural texture color pipeline.
`default_nettype none

// Procedural texture color.
//
// A request carries one surface point (i_px, i_py, i_pz, signed Q16.16) and
// is taken at a rising edge where start is high and busy is low. Every
// request gives exactly one color (o_red, o_green, o_blue), shown for one
// cycle with o_strobe high. The receiver cannot hold results off.
//
// The datapath is a five-register pipeline: input register, coordinate
// multiply, truncation parity and fraction, texture decision, and output
// color register. o_strobe is high while the result sits in the output
// color register. One request can be taken in every cycle, so the
// throughput is one point per clock; the multiply stage sets the critical
// path.
//
// Configuration goes through its own channel (i_cfg_valid, o_cfg_ready,
// i_cfg_index, i_cfg_data) and must only be written while no request is in
// flight. Writes to indexes past the register list are dropped.
//
// Reset (synchronous, active low) clears the valid bits, restores the
// register defaults (uniform mode, black colors, unit scale, zero mortar)
// and holds busy high and o_cfg_ready low until the cycle after reset ends.

module procedural_texture_color #(
    parameter int CHANNEL_BITS = 16,
    parameter int COORD_BITS   = 32
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // Request channel.
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic signed [COORD_BITS-1:0]          i_px,
    input  wire logic signed [COORD_BITS-1:0]          i_py,
    input  wire logic signed [COORD_BITS-1:0]          i_pz,
    // Result channel.
    output logic                                       o_strobe,
    output logic [CHANNEL_BITS-1:0]                    o_red,
    output logic [CHANNEL_BITS-1:0]                    o_green,
    output logic [CHANNEL_BITS-1:0]                    o_blue,
    // Configuration channel.
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [ptc_pkg::CFG_INDEX_BITS-1:0]    i_cfg_index,
    input  wire logic [3*CHANNEL_BITS-1:0]             i_cfg_data
);

    localparam int CB = 3 * CHANNEL_BITS;
    localparam int FB = ptc_pkg::FRAC_BITS;

    // Configuration registers.
    logic                               r_ready;
    logic [ptc_pkg::MODE_BITS-1:0]      r_mode;
    logic [CB-1:0]                      r_color_a;
    logic [CB-1:0]                      r_color_b;
    logic [ptc_pkg::SCALE_BITS-1:0]     r_scale;
    logic [ptc_pkg::MORTAR_BITS-1:0]    r_mortar;
    logic                               w_cfg_wr;

    // Pipeline.
    logic                               w_accept;
    logic                               r_s1_vld;
    logic signed [COORD_BITS-1:0]       r_s1_px;
    logic signed [COORD_BITS-1:0]       r_s1_py;
    logic signed [COORD_BITS-1:0]       r_s1_pz;
    logic                               r_s2_vld;
    logic                               r_s3_vld;
    ptc_pkg::t_scaled                   w_sx;
    ptc_pkg::t_scaled                   w_sy;
    ptc_pkg::t_scaled                   w_sz;
    logic [FB-1:0]                      w_fy;
    logic                               n_pick_b;
    logic                               r_s4_vld;
    logic                               r_s4_pick_b;
    logic [CB-1:0]                      w_color;
    logic                               r_out_vld;
    logic [CB-1:0]                      r_out_color;

    // Both channels open in the cycle after reset is released.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= 1'b0;
        end else begin
            r_ready <= 1'b1;
        end
    end

    assign busy        = ~r_ready;
    assign o_cfg_ready = r_ready;
    assign w_accept    = start & r_ready;
    assign w_cfg_wr    = i_cfg_valid & r_ready;

    // Register file decode.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= ptc_pkg::MODE_UNIFORM;
            r_color_a <= '0;
            r_color_b <= '0;
            r_scale   <= ptc_pkg::SCALE_RESET;
            r_mortar  <= '0;
        end else if (w_cfg_wr) begin
            unique case (i_cfg_index)
                ptc_pkg::REG_MODE:    r_mode    <= i_cfg_data[ptc_pkg::MODE_BITS-1:0];
                ptc_pkg::REG_COLOR_A: r_color_a <= i_cfg_data;
                ptc_pkg::REG_COLOR_B: r_color_b <= i_cfg_data;
                ptc_pkg::REG_SCALE:   r_scale   <= i_cfg_data[ptc_pkg::SCALE_BITS-1:0];
                ptc_pkg::REG_MORTAR:  r_mortar  <= i_cfg_data[ptc_pkg::MORTAR_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Valid bits travel alongside the datapath stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_s4_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s1_vld  <= w_accept;
            r_s2_vld  <= r_s1_vld;
            r_s3_vld  <= r_s2_vld;
            r_s4_vld  <= r_s3_vld;
            r_out_vld <= r_s4_vld;
        end
    end

    // Stage 1: capture the point.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_px <= i_px;
            r_s1_py <= i_py;
            r_s1_pz <= i_pz;
        end
    end

    // Stages 2 and 3: one scaler per axis.
    ptc_scale #(.COORD_BITS(COORD_BITS)) u_scale_x (
        .i_clk    (i_clk),
        .i_coord  (r_s1_px),
        .i_scale  (r_scale),
        .o_scaled (w_sx)
    );

    ptc_scale #(.COORD_BITS(COORD_BITS)) u_scale_y (
        .i_clk    (i_clk),
        .i_coord  (r_s1_py),
        .i_scale  (r_scale),
        .o_scaled (w_sy)
    );

    ptc_scale #(.COORD_BITS(COORD_BITS)) u_scale_z (
        .i_clk    (i_clk),
        .i_coord  (r_s1_pz),
        .i_scale  (r_scale),
        .o_scaled (w_sz)
    );

    // Stage 4: texture decision. In brick mode, odd rows shift y by half a
    // brick before the mortar test.
    assign w_fy = w_sx.int_bit ? (w_sy.frac - ptc_pkg::HALF_Q16) : w_sy.frac;

    always_comb begin
        n_pick_b = 1'b0;
        if (r_mode == ptc_pkg::MODE_CHECKER) begin
            n_pick_b = w_sx.int_bit ^ w_sy.int_bit ^ w_sz.int_bit;
        end else if (r_mode == ptc_pkg::MODE_BRICK) begin
            n_pick_b = (w_sx.frac < r_mortar) | (w_fy < r_mortar);
        end
    end

    always_ff @(posedge i_clk) begin
        r_s4_pick_b <= n_pick_b;
    end

    // Stage 5: output color register.
    assign w_color = r_s4_pick_b ? r_color_b : r_color_a;

    always_ff @(posedge i_clk) begin
        r_out_color <= w_color;
    end

    assign o_strobe = r_out_vld;
    assign o_red    = r_out_color[CHANNEL_BITS-1:0];
    assign o_green  = r_out_color[2*CHANNEL_BITS-1:CHANNEL_BITS];
    assign o_blue   = r_out_color[3*CHANNEL_BITS-1:2*CHANNEL_BITS];

endmodule

`default_nettype wire

### hdl/ptc_checker.sv
// Port-level checks for the procedural texture color block and their binding.
`default_nettype none

module ptc_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_strobe,
    input wire logic o_cfg_ready
);

    // Every accepted request yields a result.
    a_req_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##5 o_strobe)
        else $error("accepted request produced no result");

    // No result appears without a matching accepted request.
    a_result_has_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, 5))
        else $error("result without a matching request");

    // Once open, the request channel stays open until reset.
    a_busy_stays_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |=> !busy)
        else $error("busy rose outside reset");

    // Reset clears any result in flight and closes the configuration channel.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_strobe && !o_cfg_ready))
        else $error("result or config ready after reset");

endmodule

bind procedural_texture_color ptc_checker u_ptc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_strobe    (o_strobe),
    .o_cfg_ready (o_cfg_ready)
);

`default_nettype wire
